FILE: design/prrtp_pkg.sv
package prrtp_pkg;

   // default table size
   localparam int MAX_SLOTS_DEF = 16;

   // priority value meaning "no task", also the reset value of the best priority
   localparam logic [7:0] PRIO_NONE = 8'd255;

   // request codes
   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_PICK   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FAIL    = 2'd1;
   localparam logic [1:0] ST_NO_TASK = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] task_priority;
      logic [3:0] slot_index;
   } req_data_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] chosen_slot;
      logic [7:0] best_priority;
   } rsp_data_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch;
      logic       dispatch_create;
      logic       dispatch_remove;
      logic       dispatch_pick;
      logic       advance;
      logic       issue;
      logic       commit_create;
      logic       finish_remove;
      logic       commit_pick;
      logic       respond;
      logic [1:0] rsp_code;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       full;
      logic       few;
      logic       rmv_ok;
      logic       slot_free;
      logic       left_nz;
      logic       rd_vld;
      logic       hit;
   } ctrl_sts_type;

endpackage

FILE: design/prrtp_ctrl.sv
module prrtp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  prrtp_pkg::ctrl_sts_type sts,
   output prrtp_pkg::ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_CREATE   = 3'd2;
   localparam logic [2:0] S_REMOVE   = 3'd3;
   localparam logic [2:0] S_PICK     = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.rsp_code = prrtp_pkg::ST_FAIL;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.req_type)
               prrtp_pkg::REQ_CREATE: begin
                  if (sts.full) begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.dispatch_create = 1'b1;
                     state_in            = S_CREATE;
                  end
               end
               prrtp_pkg::REQ_REMOVE: begin
                  if (!sts.rmv_ok) begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.dispatch_remove = 1'b1;
                     state_in            = S_REMOVE;
                  end
               end
               prrtp_pkg::REQ_PICK: begin
                  if (sts.few) begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = prrtp_pkg::ST_NO_TASK;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.dispatch_pick = 1'b1;
                     state_in          = S_PICK;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_CREATE: begin
            if (sts.slot_free) begin
               cmd.commit_create = 1'b1;
               cmd.respond       = 1'b1;
               cmd.rsp_code      = prrtp_pkg::ST_OK;
               state_in          = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_REMOVE: begin
            if (!sts.left_nz && !sts.rd_vld) begin
               cmd.finish_remove = 1'b1;
               cmd.respond       = 1'b1;
               cmd.rsp_code      = prrtp_pkg::ST_OK;
               state_in          = S_IDLE;
            end else begin
               cmd.issue = sts.left_nz;
            end
         end
         S_PICK: begin
            if (sts.hit) begin
               cmd.commit_pick = 1'b1;
               cmd.respond     = 1'b1;
               cmd.rsp_code    = prrtp_pkg::ST_OK;
               state_in        = S_IDLE;
            end else if (!sts.left_nz && !sts.rd_vld) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.issue = sts.left_nz;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_resp_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmd.respond)
      else $error("response issued from idle");

endmodule

FILE: design/prrtp_dpath.sv
module prrtp_dpath #(
   parameter int MAX_SLOTS = prrtp_pkg::MAX_SLOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  prrtp_pkg::req_data_type req_data,
   input  prrtp_pkg::ctrl_cmd_type cmd,
   output prrtp_pkg::ctrl_sts_type sts,
   output logic                    rsp_valid,
   output prrtp_pkg::rsp_data_type rsp_data
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

   // round-robin successor over slots 1..MAX_SLOTS-1
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
      logic [SLOT_W:0] n;
      n = (SLOT_W+1)'(p) + (SLOT_W+1)'(1);
      if (n >= (SLOT_W+1)'(MAX_SLOTS)) begin
         return SLOT_W'(1);
      end
      return n[SLOT_W-1:0];
   endfunction

   logic [7:0]              prio_mem [MAX_SLOTS];

   prrtp_pkg::req_data_type req_ff;
   logic [MAX_SLOTS-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [7:0]              min_ff, min_in;
   logic [SLOT_W-1:0]       rr_ff, rr_in;
   logic [SLOT_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic [7:0]              acc_ff, acc_in;
   logic [7:0]              rd_data_ff;
   logic                    rd_used_ff;
   logic [SLOT_W-1:0]       rd_addr_ff;
   logic                    rd_vld_ff;
   logic                    rsp_valid_ff;
   prrtp_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic [SLOT_W-1:0]       idx_s;
   logic [SLOT_W-1:0]       chosen;

   assign idx_s = SLOT_W'(req_ff.slot_index);

   assign sts.req_type  = req_ff.req_type;
   assign sts.full      = (count_ff == CNT_W'(MAX_SLOTS));
   assign sts.few       = (count_ff <= CNT_W'(1));
   assign sts.rmv_ok    = (32'(req_ff.slot_index) < 32'(MAX_SLOTS)) && used_ff[idx_s];
   assign sts.slot_free = !used_ff[addr_ff];
   assign sts.left_nz   = (left_ff != '0);
   assign sts.rd_vld    = rd_vld_ff;
   assign sts.hit       = rd_vld_ff && rd_used_ff && (rd_data_ff == min_ff);

   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      min_in   = min_ff;
      rr_in    = rr_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      chosen   = '0;
      if (cmd.dispatch_create) begin
         addr_in = '0;
      end
      if (cmd.dispatch_remove) begin
         used_in[idx_s] = 1'b0;
         count_in       = count_ff - CNT_W'(1);
         addr_in        = '0;
         left_in        = CNT_W'(MAX_SLOTS);
         acc_in         = prrtp_pkg::PRIO_NONE;
      end
      if (cmd.dispatch_pick) begin
         addr_in = next_slot(rr_ff);
         left_in = CNT_W'(MAX_SLOTS - 1);
      end
      if (cmd.advance) begin
         addr_in = addr_ff + SLOT_W'(1);
      end
      if (cmd.issue) begin
         if (req_ff.req_type == prrtp_pkg::REQ_PICK) begin
            addr_in = next_slot(addr_ff);
         end else begin
            addr_in = addr_ff + SLOT_W'(1);
         end
         left_in = left_ff - CNT_W'(1);
      end
      // running minimum for the remove rescan
      if (rd_vld_ff && rd_used_ff && (rd_data_ff < acc_ff)) begin
         acc_in = rd_data_ff;
      end
      if (cmd.commit_create) begin
         used_in[addr_ff] = 1'b1;
         count_in         = count_ff + CNT_W'(1);
         // the first task does not lower the best priority
         if ((count_ff != '0) && (req_ff.task_priority < min_ff)) begin
            min_in = req_ff.task_priority;
         end
         chosen = addr_ff;
      end
      if (cmd.finish_remove) begin
         min_in = acc_ff;
         chosen = idx_s;
      end
      if (cmd.commit_pick) begin
         rr_in  = rd_addr_ff;
         chosen = rd_addr_ff;
      end
      rsp_data_in.status        = cmd.rsp_code;
      rsp_data_in.chosen_slot   = 4'(chosen);
      rsp_data_in.best_priority = min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         min_ff       <= prrtp_pkg::PRIO_NONE;
         rr_ff        <= '0;
         left_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         rr_ff        <= rr_in;
         left_ff      <= left_in;
         rd_vld_ff    <= cmd.issue;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      addr_ff     <= addr_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // priority table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit_create) begin
         prio_mem[addr_ff] <= req_ff.task_priority;
      end
      if (cmd.issue) begin
         rd_data_ff <= prio_mem[addr_ff];
         rd_used_ff <= used_ff[addr_ff];
         rd_addr_ff <= addr_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_occ: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(count_ff))
      else $error("task count differs from slot occupancy");

   a_create_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_create |-> !used_ff[addr_ff])
      else $error("create into occupied slot");

   a_pick_user: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_pick |-> (rd_addr_ff != '0) && used_ff[rd_addr_ff])
      else $error("pick of slot 0 or a free slot");

endmodule

FILE: design/priority_round_robin_task_picker_top.sv
// Task slot scheduler. A request (create, remove or pick) is taken when start
// is high and busy is low; exactly one response follows, shown for a single
// cycle with rsp_valid high. The receiver cannot stall: capture rsp_data in
// the cycle rsp_valid is high. busy drops in that same cycle, so the next
// request can be taken while the response is on the ports. A request is
// refused straight from the dispatch state for a full table, a bad remove
// slot, fewer than two tasks or an unused code. The remove and pick scans
// walk the table one slot per cycle through the single read port of the
// priority memory; a create scan steps through the used flags from slot 0.
module priority_round_robin_task_picker_top #(
   parameter int MAX_SLOTS = prrtp_pkg::MAX_SLOTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  prrtp_pkg::req_data_type req_data,
   output logic                    rsp_valid,
   output prrtp_pkg::rsp_data_type rsp_data
);

   prrtp_pkg::ctrl_cmd_type cmd;
   prrtp_pkg::ctrl_sts_type sts;

   // sequencer: decides the request path, steps the scan, issues the response
   prrtp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // slot table, priority memory, best priority, round-robin pointer
   prrtp_dpath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// Checks the task slot scheduler with create, remove and pick requests.
// A shadow copy of the slot table predicts each response at the edge where the
// request is taken, and every strobed response is compared against the oldest
// prediction still waiting.
module testbench;
   import prrtp_pkg::*;

   localparam int         MAX_SLOTS      = MAX_SLOTS_DEF;
   localparam int         RANDOM_ITEMS   = 1100;
   localparam int         DRAIN_EVERY    = 250;
   // longest scan is a remove, which reads every slot of the table
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         SETTLE_CYCLES  = MAX_SLOTS + 8;
   // code the block must refuse
   localparam logic [1:0] REQ_UNUSED     = 2'd3;

   // Shadow slot table plus the queue of responses still owed by the block.
   class slot_table_checker;
      bit           slot_used [MAX_SLOTS];
      logic [7:0]   slot_prio [MAX_SLOTS];
      int           task_count;
      logic [7:0]   best_prio;
      int           rr_ptr;
      rsp_data_type expected_rsp [$];
      int           errors;
      int           checked;
      int           req_seen [4];
      int           status_seen [4];

      function new();
         foreach (slot_used[i]) begin
            slot_used[i] = 1'b0;
            slot_prio[i] = '0;
         end
         foreach (req_seen[i]) begin
            req_seen[i]    = 0;
            status_seen[i] = 0;
         end
         task_count = 0;
         best_prio  = PRIO_NONE;
         rr_ptr     = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      // round-robin walk over the user slots 1..MAX_SLOTS-1
      function int next_slot(int p);
         int n;
         n = p + 1;
         if (n >= MAX_SLOTS || n < 1) begin
            n = 1;
         end
         return n;
      endfunction

      function rsp_data_type predict_outcome(req_data_type r);
         rsp_data_type o;
         int           i;
         int           p;
         int           hit;
         o.status      = ST_FAIL;
         o.chosen_slot = '0;
         case (r.req_type)
            REQ_CREATE: begin
               if (task_count < MAX_SLOTS) begin
                  hit = -1;
                  for (i = 0; i < MAX_SLOTS; i++) begin
                     if (!slot_used[i] && hit < 0) begin
                        hit = i;
                     end
                  end
                  if (hit >= 0) begin
                     slot_used[hit] = 1'b1;
                     slot_prio[hit] = r.task_priority;
                     task_count++;
                     // the very first task leaves the best priority alone
                     if (task_count != 1 && r.task_priority < best_prio) begin
                        best_prio = r.task_priority;
                     end
                     o.status      = ST_OK;
                     o.chosen_slot = 4'(hit);
                  end
               end
            end
            REQ_REMOVE: begin
               if (int'(r.slot_index) < MAX_SLOTS && slot_used[r.slot_index]) begin
                  slot_used[r.slot_index] = 1'b0;
                  if (task_count > 0) begin
                     task_count--;
                  end
                  best_prio = PRIO_NONE;
                  for (i = 0; i < MAX_SLOTS; i++) begin
                     if (slot_used[i] && slot_prio[i] < best_prio) begin
                        best_prio = slot_prio[i];
                     end
                  end
                  o.status      = ST_OK;
                  o.chosen_slot = r.slot_index;
               end
            end
            REQ_PICK: begin
               if (task_count <= 1) begin
                  o.status = ST_NO_TASK;
               end else begin
                  p   = rr_ptr;
                  hit = 0;
                  for (i = 1; i < MAX_SLOTS && hit == 0; i++) begin
                     p = next_slot(p);
                     if (slot_used[p] && slot_prio[p] == best_prio) begin
                        rr_ptr        = p;
                        o.status      = ST_OK;
                        o.chosen_slot = 4'(p);
                        hit           = 1;
                     end
                  end
               end
            end
            default: begin
               // unused code: refused, table untouched
            end
         endcase
         o.best_priority = best_prio;
         return o;
      endfunction

      function void note_request(req_data_type r);
         req_seen[r.req_type]++;
         expected_rsp.push_back(predict_outcome(r));
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_data_type got);
         rsp_data_type want;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding, expected none, got %0d/%0d/%0d",
                     $time, got.status, got.chosen_slot, got.best_priority);
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         status_seen[want.status]++;
         compare_field("status", 8'(want.status), 8'(got.status));
         compare_field("chosen_slot", 8'(want.chosen_slot), 8'(got.chosen_slot));
         compare_field("best_priority", want.best_priority, got.best_priority);
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_data_type req_data;
   logic         rsp_valid;
   rsp_data_type rsp_data;

   slot_table_checker sb = new();
   int                idle_cycles;

   priority_round_robin_task_picker_top #(
      .MAX_SLOTS (MAX_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Responses cannot be held off: grab each one on the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_response(rsp_data);
      end
   end

   // Watchdog: too long without a request or a response taken means a hang.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic req_data_type make_req(logic [1:0] kind, logic [7:0] prio,
                                             logic [3:0] idx);
      req_data_type r;
      r.req_type      = kind;
      r.task_priority = prio;
      r.slot_index    = idx;
      return r;
   endfunction

   // Present a request on the falling edge and hold it until the block takes
   // it; start stays high on return so back-to-back requests need no toggle.
   task automatic issue_request(input req_data_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do begin
         @(posedge clock);
      end while (busy);
      sb.note_request(r);
   endtask

   // Sender gap with start low, its length set by n; the data lines carry junk meanwhile.
   task automatic hold_off(input int n);
      if (n > 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= req_data_type'($urandom);
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   // Priorities lean toward a few close values so ties at the best level are common.
   function automatic logic [7:0] random_priority();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom);
         1:       return 8'($urandom_range(0, 3) * 85);
         default: return 8'($urandom_range(16, 19));
      endcase
   endfunction

   // Mostly legal traffic shaped by the shadow table: the run alternates
   // between filling and draining phases so the table hits both full and empty.
   function automatic req_data_type make_random_request(int n);
      req_data_type r;
      int           roll;
      int           create_w;
      int           remove_w;
      int           occupied [$];
      r.task_priority = random_priority();
      r.slot_index    = 4'($urandom_range(0, 15));
      if ((n / 60) % 2 == 0) begin
         create_w = 55;
         remove_w = 15;
      end else begin
         create_w = 15;
         remove_w = 55;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         r.req_type = REQ_UNUSED;
      end else if (roll < 3 + create_w) begin
         r.req_type = REQ_CREATE;
      end else if (roll < 3 + create_w + remove_w) begin
         r.req_type = REQ_REMOVE;
         foreach (sb.slot_used[k]) begin
            if (sb.slot_used[k]) begin
               occupied.push_back(k);
            end
         end
         // one in ten removes aims anywhere, usually at a free slot
         if (occupied.size() > 0 && $urandom_range(0, 9) != 0) begin
            r.slot_index = 4'(occupied[$urandom_range(0, occupied.size() - 1)]);
         end
      end else begin
         r.req_type = REQ_PICK;
      end
      return r;
   endfunction

   // Directed opening: refused requests on an empty table, the first-task
   // rule, a pick with no user slot at the best level, a full table, slot 0
   // removal and the round-robin order.
   task automatic directed_sequence();
      int k;
      issue_request(make_req(REQ_PICK, 8'h00, 4'd0));        // empty: no task
      issue_request(make_req(REQ_REMOVE, 8'h00, 4'd3));      // free slot
      issue_request(make_req(REQ_UNUSED, 8'hFF, 4'd15));     // bad code
      issue_request(make_req(REQ_CREATE, 8'h00, 4'd0));      // first task, best stays 255
      issue_request(make_req(REQ_PICK, 8'h00, 4'd0));        // one task only
      issue_request(make_req(REQ_CREATE, 8'd10, 4'd0));
      issue_request(make_req(REQ_REMOVE, 8'h00, 4'd1));      // best falls back to slot 0
      issue_request(make_req(REQ_CREATE, 8'hFF, 4'd0));
      issue_request(make_req(REQ_PICK, 8'h00, 4'd0));        // only slot 0 at best
      for (k = 2; k < MAX_SLOTS; k++) begin
         issue_request(make_req(REQ_CREATE, (k % 2 == 0) ? 8'h55 : 8'hAA, 4'(k)));
      end
      issue_request(make_req(REQ_CREATE, 8'h01, 4'd0));      // table full
      issue_request(make_req(REQ_REMOVE, 8'h00, 4'd0));      // controller slot may go
      issue_request(make_req(REQ_PICK, 8'h00, 4'd0));
      issue_request(make_req(REQ_PICK, 8'h00, 4'd0));
      issue_request(make_req(REQ_REMOVE, 8'h00, 4'd15));
      issue_request(make_req(REQ_REMOVE, 8'h00, 4'd15));     // already free
      wait_until_drained();
   endtask

   initial begin
      int sent;
      int burst;
      int next_drain;
      req_data_type r;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_sequence();

      // Random part: bursts of random length, mostly short with the odd long
      // gap-free run; gaps span the whole range of response latencies.
      sent       = 0;
      next_drain = DRAIN_EVERY;
      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         repeat (burst) begin
            if (sent < RANDOM_ITEMS) begin
               r = make_random_request(sent);
               issue_request(r);
               if (r.req_type != REQ_UNUSED) begin
                  sent++;
               end
            end
         end
         if (sent >= next_drain) begin
            wait_until_drained();
            next_drain += DRAIN_EVERY;
         end else begin
            hold_off($urandom_range(0, 20));
         end
      end

      wait_until_drained();
      // catch any stray strobe after the last response
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Requests: %0d create, %0d remove, %0d pick, %0d unused code",
               sb.req_seen[REQ_CREATE], sb.req_seen[REQ_REMOVE],
               sb.req_seen[REQ_PICK], sb.req_seen[REQ_UNUSED]);
      $display("Responses checked: %0d (%0d ok, %0d refused, %0d no user task)",
               sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_FAIL],
               sb.status_seen[ST_NO_TASK]);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
